### rtl/core/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared widths, register codes and beat types of the primary ray generator.
// ----------------------------------------------------------------------------
package rpg_pkg;

	localparam int FRAC_BITS = 14;
	localparam int MAX_DIM   = 2048;

	localparam int DIM_W   = 12;
	localparam int PIX_W   = 11;
	localparam int IDX_W   = 22;
	localparam int SCALE_W = 16;
	localparam int COL_W   = 48;
	localparam int COMP_W  = 16;
	localparam int DIR_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam int NDC_NW  = DIM_W + FRAC_BITS;
	localparam int MAG_W   = NDC_NW + SCALE_W;
	localparam int NORM_W  = 31;
	localparam int SQ_W    = 64;
	localparam int LEN_W   = 32;
	localparam int UNUM_W  = NORM_W + FRAC_BITS + 1;
	localparam int UQ_W    = 16;
	localparam int UNIT_W  = UQ_W + 1;
	localparam int DIR_MAX = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VP_WIDTH,
		CFG_VP_HEIGHT,
		CFG_SCALE_X,
		CFG_SCALE_Y,
		CFG_RIGHT,
		CFG_UP,
		CFG_BACK
	} cfg_idx_t;

	typedef struct packed {
		logic             neg_x;
		logic             neg_y;
		logic [IDX_W-1:0] idx;
	} side_t;

	typedef struct packed {
		side_t                       side;
		logic [2:0][NORM_W-1:0]      mag;
	} root_tag_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic [IDX_W-1:0]        pixel_index;
	} out_t;

	// zero acts as one, anything above the largest viewport is clipped
	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

### rtl/core/primary_ray_direction_gen_unit.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_gen_unit
// Pinhole camera primary ray generator: pixel to NDC, inverse projection
// scale, normalization and view basis rotation, fully pipelined.
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  in       in_valid, in_stall, pixel_x, pixel_y       into block
//  out      out_valid, out_stall, dir_x/y/z, index     out of block
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  into block
//
// One pixel is taken every cycle while in_stall is low; the path to the queue
// runs through the 26-stage NDC divider, 32-stage square root and 16-stage divider.
// A two-beat output queue holds results; the pipeline freezes only while it
// is full, so in_stall is a registered function of the queue fill.
// Reset clears all valid bits and loads width 1, height 1, scales 1.0, zero
// basis. cfg_ready is always high.
// ----------------------------------------------------------------------------
module primary_ray_direction_gen_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rpg_pkg::PIX_W-1:0]            pixel_x,
	input  logic [rpg_pkg::PIX_W-1:0]            pixel_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rpg_pkg::DIR_W-1:0]     dir_x,
	output logic signed [rpg_pkg::DIR_W-1:0]     dir_y,
	output logic signed [rpg_pkg::DIR_W-1:0]     dir_z,
	output logic [rpg_pkg::IDX_W-1:0]            pixel_index,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpg_pkg::COL_W-1:0]            cfg_data
);
	import rpg_pkg::*;

	// configuration
	logic [DIM_W-1:0]       width_q, height_q;
	logic [SCALE_W-1:0]     sx_q, sy_q;
	logic [2:0][COL_W-1:0]  col_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			sx_q     <= SCALE_W'(1 << 10);
			sy_q     <= SCALE_W'(1 << 10);
			col_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VP_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_VP_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_SCALE_X:   sx_q     <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Y:   sy_q     <= cfg_data[SCALE_W-1:0];
				CFG_RIGHT:     col_q[0] <= cfg_data;
				CFG_UP:        col_q[1] <= cfg_data;
				CFG_BACK:      col_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output queue is full
	logic [1:0] count_q;
	logic       en;
	assign en       = count_q != 2'd2;
	assign in_stall = !en;

	// stage 1: NDC numerators, pixel index
	logic [DIM_W-1:0]         w_eff, h_eff;
	logic signed [DIM_W+1:0]  dx, dy;
	logic [DIM_W-1:0]         ax, ay;
	logic [IDX_W:0]           idx_c;

	always_comb begin
		w_eff = eff_size(width_q);
		h_eff = eff_size(height_q);
		dx    = signed'({2'b00, pixel_x, 1'b0}) - signed'({2'b00, w_eff});
		dy    = signed'({2'b00, pixel_y, 1'b0}) - signed'({2'b00, h_eff});
		ax    = dx[DIM_W+1] ? DIM_W'(-dx) : dx[DIM_W-1:0];
		ay    = dy[DIM_W+1] ? DIM_W'(-dy) : dy[DIM_W-1:0];
		idx_c = (IDX_W+1)'(pixel_y) * (IDX_W+1)'(w_eff) + (IDX_W+1)'(pixel_x);
	end

	logic                        v_s1;
	logic [1:0][NDC_NW-1:0]      num_s1;
	logic [1:0][DIM_W-1:0]       den_s1;
	side_t                       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1[0]     <= {ax, {FRAC_BITS{1'b0}}};
			num_s1[1]     <= {ay, {FRAC_BITS{1'b0}}};
			den_s1[0]     <= w_eff;
			den_s1[1]     <= h_eff;
			side_s1.neg_x <= dx[DIM_W+1];
			side_s1.neg_y <= dy[DIM_W+1];
			side_s1.idx   <= idx_c[IDX_W-1:0];
		end
	end

	// NDC magnitudes, truncated toward zero
	logic                   ndc_v;
	logic [1:0][NDC_NW-1:0] ndc_q;
	side_t                  ndc_side;

	rpg_div #(
		.LANES(2), .NW(NDC_NW), .DW(DIM_W), .QW(NDC_NW), .TW($bits(side_t))
	) u_ndc_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .num(num_s1), .den(den_s1), .in_tag(side_s1),
		.out_valid(ndc_v), .quo(ndc_q), .out_tag(ndc_side)
	);

	// stage 2: projection scale
	logic                   v_s2;
	logic [2:0][MAG_W-1:0]  mag_s2;
	side_t                  side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= ndc_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2[0] <= MAG_W'(ndc_q[0]) * MAG_W'(sx_q);
			mag_s2[1] <= MAG_W'(ndc_q[1]) * MAG_W'(sy_q);
			mag_s2[2] <= MAG_W'(1) << (FRAC_BITS + 10);
			side_s2   <= ndc_side;
		end
	end

	logic                    nrm_v;
	logic [2:0][NORM_W-1:0]  nrm_mag;
	side_t                   nrm_side;

	rpg_norm #(.TW($bits(side_t))) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .mag_in(mag_s2), .in_tag(side_s2),
		.out_valid(nrm_v), .mag_out(nrm_mag), .out_tag(nrm_side)
	);

	// stages 3 and 4: sum of squares
	logic                       v_s3, v_s4;
	logic [2:0][2*NORM_W-1:0]   sq_s3;
	root_tag_t                  tag_s3, tag_s4;
	logic [SQ_W-1:0]            sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= nrm_v;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s3[l] <= (2*NORM_W)'(nrm_mag[l]) * (2*NORM_W)'(nrm_mag[l]);
			end
			tag_s3.side <= nrm_side;
			tag_s3.mag  <= nrm_mag;
			sum_s4      <= SQ_W'(sq_s3[0]) + SQ_W'(sq_s3[1]) + SQ_W'(sq_s3[2]);
			tag_s4      <= tag_s3;
		end
	end

	logic              rt_v;
	logic [LEN_W-1:0]  rt_len;
	root_tag_t         rt_tag;

	rpg_isqrt #(.TW($bits(root_tag_t))) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .rad(sum_s4), .in_tag(tag_s4),
		.out_valid(rt_v), .root(rt_len), .out_tag(rt_tag)
	);

	// unit vector: (mag << FRAC + len/2) / len, rounded
	logic [2:0][UNUM_W-1:0] unum;
	logic [2:0][LEN_W-1:0]  uden;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			unum[l] = (UNUM_W'(rt_tag.mag[l]) << FRAC_BITS) + UNUM_W'(rt_len >> 1);
			uden[l] = rt_len;
		end
	end

	logic                  ud_v;
	logic [2:0][UQ_W-1:0]  ud_q;
	side_t                 ud_side;

	rpg_div #(
		.LANES(3), .NW(UNUM_W), .DW(LEN_W), .QW(UQ_W), .TW($bits(side_t))
	) u_unit_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(rt_v), .num(unum), .den(uden), .in_tag(rt_tag.side),
		.out_valid(ud_v), .quo(ud_q), .out_tag(ud_side)
	);

	// put the signs back; z always points down the view axis
	logic [2:0][UNIT_W-1:0] unit;
	logic [2:0]             neg;

	always_comb begin
		neg = {1'b1, ud_side.neg_y, ud_side.neg_x};
		for (int l = 0; l < 3; l++) begin
			unit[l] = neg[l] ? -{1'b0, ud_q[l]} : {1'b0, ud_q[l]};
		end
	end

	logic rot_v;
	out_t rot_res;

	rpg_rotate u_rotate (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(ud_v), .unit(unit), .col(col_q), .in_idx(ud_side.idx),
		.out_valid(rot_v), .result(rot_res)
	);

	// two-beat output queue, head in slot 0
	out_t slot0_q, slot1_q;
	logic push, pop;

	assign push = en && rot_v;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				slot0_q <= rot_res;
			end else begin
				slot1_q <= rot_res;
			end
		end else if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (pop && push) begin
			slot0_q <= rot_res;
		end
	end

	assign out_valid   = count_q != 2'd0;
	assign dir_x       = slot0_q.dir_x;
	assign dir_y       = slot0_q.dir_y;
	assign dir_z       = slot0_q.dir_z;
	assign pixel_index = slot0_q.pixel_index;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue fill out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> (count_q == 2'd2 && in_stall))
		else $error("full queue released without a pop");

	a_dir_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dir_x >= -DIR_MAX && dir_x <= DIR_MAX
			&& dir_y >= -DIR_MAX && dir_y <= DIR_MAX
			&& dir_z >= -DIR_MAX && dir_z <= DIR_MAX))
		else $error("direction beyond saturation bound");

endmodule

### rtl/core/rpg_div.sv
// ----------------------------------------------------------------------------
// rpg_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The caller guarantees num >> QW is below den.
// ----------------------------------------------------------------------------
module rpg_div #(
	parameter int LANES = 2,
	parameter int NW    = 26,
	parameter int DW    = 12,
	parameter int QW    = 26,
	parameter int TW    = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NW-1:0]    num,
	input  logic [LANES-1:0][DW-1:0]    den,
	input  logic [TW-1:0]               in_tag,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    quo,
	output logic [TW-1:0]               out_tag
);

	// index k holds what enters stage k; index QW is the last register
	logic [QW:0]                        vld_s;
	logic [QW:0][LANES-1:0][DW-1:0]     rem_s;
	logic [QW:0][LANES-1:0][QW-1:0]     low_s;
	logic [QW:0][LANES-1:0][QW-1:0]     qt_s;
	logic [QW:0][LANES-1:0][DW-1:0]     den_s;
	logic [QW:0][TW-1:0]                tag_s;

	always_comb begin
		vld_s[0] = in_valid;
		tag_s[0] = in_tag;
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = DW'(num[l] >> QW);
			low_s[0][l] = num[l][QW-1:0];
			qt_s[0][l]  = '0;
			den_s[0][l] = den[l];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LANES-1:0][DW:0]   sh;
		logic [LANES-1:0]         ge;
		logic [LANES-1:0][DW:0]   diff;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				sh[l]   = {rem_s[k][l], low_s[k][l][QW-1-k]};
				ge[l]   = sh[l] >= {1'b0, den_s[k][l]};
				diff[l] = sh[l] - {1'b0, den_s[k][l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= ge[l] ? diff[l][DW-1:0] : sh[l][DW-1:0];
					low_s[k+1][l] <= low_s[k][l];
					qt_s[k+1][l]  <= qt_s[k][l] | (QW'(ge[l]) << (QW-1-k));
					den_s[k+1][l] <= den_s[k][l];
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = qt_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

### rtl/core/rpg_norm.sv
// ----------------------------------------------------------------------------
// rpg_norm
// Block normalization: scale three magnitudes by a common power of two so
// the largest lands in [2^30, 2^31). Three stages: max, leading one, shift.
// ----------------------------------------------------------------------------
module rpg_norm #(
	parameter int TW = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [2:0][rpg_pkg::MAG_W-1:0]      mag_in,
	input  logic [TW-1:0]                       in_tag,
	output logic                                out_valid,
	output logic [2:0][rpg_pkg::NORM_W-1:0]     mag_out,
	output logic [TW-1:0]                       out_tag
);
	import rpg_pkg::*;

	localparam int POS_W = $clog2(MAG_W);
	localparam logic [POS_W-1:0] TOP = POS_W'(NORM_W - 1);

	logic                   v_s1, v_s2, v_s3;
	logic [2:0][MAG_W-1:0]  mag_s1, mag_s2;
	logic [MAG_W-1:0]       max_s1;
	logic [POS_W-1:0]       pos_s2;
	logic [2:0][NORM_W-1:0] mag_s3;
	logic [TW-1:0]          tag_s1, tag_s2, tag_s3;

	logic [MAG_W-1:0]       max_c;
	logic [POS_W-1:0]       pos_c;
	logic [2:0][MAG_W-1:0]  sh_c;

	always_comb begin
		max_c = mag_in[0];
		if (mag_in[1] > max_c) begin
			max_c = mag_in[1];
		end
		if (mag_in[2] > max_c) begin
			max_c = mag_in[2];
		end
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (max_s1[b]) begin
				pos_c = POS_W'(b);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (pos_s2 > TOP) begin
				sh_c[l] = mag_s2[l] >> (pos_s2 - TOP);
			end else begin
				sh_c[l] = mag_s2[l] << (TOP - pos_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			max_s1 <= max_c;
			tag_s1 <= in_tag;
			mag_s2 <= mag_s1;
			pos_s2 <= pos_c;
			tag_s2 <= tag_s1;
			for (int l = 0; l < 3; l++) begin
				mag_s3[l] <= sh_c[l][NORM_W-1:0];
			end
			tag_s3 <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign mag_out   = mag_s3;
	assign out_tag   = tag_s3;

endmodule

### rtl/core/rpg_isqrt.sv
// ----------------------------------------------------------------------------
// rpg_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module rpg_isqrt #(
	parameter int TW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rpg_pkg::SQ_W-1:0]    rad,
	input  logic [TW-1:0]               in_tag,
	output logic                        out_valid,
	output logic [rpg_pkg::LEN_W-1:0]   root,
	output logic [TW-1:0]               out_tag
);
	import rpg_pkg::*;

	localparam int STG = SQ_W / 2;

	logic [STG:0]              vld_s;
	logic [STG:0][SQ_W-1:0]    v_s;
	logic [STG:0][SQ_W-1:0]    r_s;
	logic [STG:0][TW-1:0]      tag_s;

	assign vld_s[0] = in_valid;
	assign v_s[0]   = rad;
	assign r_s[0]   = '0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < STG; k++) begin : g_stage
		localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W:0] trial;
		logic          take;

		assign trial = {1'b0, r_s[k]} + BIT;
		assign take  = {1'b0, v_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				if (take) begin
					v_s[k+1] <= v_s[k] - trial[SQ_W-1:0];
					r_s[k+1] <= (r_s[k] >> 1) + BIT[SQ_W-1:0];
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[STG];
	assign root      = r_s[STG][LEN_W-1:0];
	assign out_tag   = tag_s[STG];

endmodule

### rtl/core/rpg_rotate.sv
// ----------------------------------------------------------------------------
// rpg_rotate
// View basis rotation: nine products, column sums, then round, saturate.
// ----------------------------------------------------------------------------
module rpg_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [2:0][rpg_pkg::UNIT_W-1:0]     unit,
	input  logic [2:0][rpg_pkg::COL_W-1:0]      col,
	input  logic [rpg_pkg::IDX_W-1:0]           in_idx,
	output logic                                out_valid,
	output rpg_pkg::out_t                       result
);
	import rpg_pkg::*;

	localparam int PROD_W = COMP_W + UNIT_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = ACC_W - FRAC_BITS;

	logic                     v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [ACC_W-1:0]  acc_s2 [3];
	logic [IDX_W-1:0]         idx_s1, idx_s2;
	out_t                     res_s3;

	logic signed [ACC_W-1:0]  mag_c [3];
	logic [Q_W-1:0]           q_c [3];
	logic [DIR_W-1:0]         d_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = acc_s2[j][ACC_W-1] ? -acc_s2[j] : acc_s2[j];
			q_c[j]   = Q_W'((ACC_W'(mag_c[j]) + ACC_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			if (q_c[j] > Q_W'(DIR_MAX)) begin
				q_c[j] = Q_W'(DIR_MAX);
			end
			d_c[j] = acc_s2[j][ACC_W-1] ? -q_c[j][DIR_W-1:0] : q_c[j][DIR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s1[j][i] <= signed'(col[i][COMP_W*j +: COMP_W]) * signed'(unit[i]);
				end
				acc_s2[j] <= ACC_W'(prod_s1[j][0]) + ACC_W'(prod_s1[j][1])
					+ ACC_W'(prod_s1[j][2]);
			end
			idx_s1             <= in_idx;
			idx_s2             <= idx_s1;
			res_s3.dir_x       <= d_c[0];
			res_s3.dir_y       <= d_c[1];
			res_s3.dir_z       <= d_c[2];
			res_s3.pixel_index <= idx_s2;
		end
	end

	assign out_valid = v_s3;
	assign result    = res_s3;

endmodule
